// ===== src/srcomp_pkg.sv =====
`default_nettype none
package srcomp_pkg;

  localparam int unsigned DATA_W      = 64;
  localparam int unsigned MUL_DIGIT_W = 16;
  localparam int unsigned MUL_STEPS   = DATA_W / MUL_DIGIT_W;
  localparam int unsigned MUL_CNT_W   = $clog2(MUL_STEPS);
  localparam int unsigned DIV_CNT_W   = $clog2(DATA_W);

  localparam int unsigned KIND_W  = 2;
  localparam int unsigned RAW_W   = 20;
  localparam int unsigned VALUE_W = 33;
  localparam int unsigned CFG_W   = 64;
  localparam int unsigned CFG_IDX_W = 3;

  // Reading types
  typedef enum logic [KIND_W-1:0] {
    KIND_TEMP  = 2'd0,
    KIND_PRESS = 2'd1,
    KIND_HUM   = 2'd2,
    KIND_NONE  = 2'd3
  } kind_e;

  // Calibration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_TEMP   = 3'd0,
    CFG_P_LOW  = 3'd1,
    CFG_P_HIGH = 3'd2,
    CFG_P_NINE = 3'd3,
    CFG_H_LOW  = 3'd4,
    CFG_H_HIGH = 3'd5
  } cfg_idx_e;

  // Largest humidity result: the upper clamp value after the shift
  localparam logic [VALUE_W-1:0] HUM_MAX_OUT = 33'd102400;

endpackage
`default_nettype wire

// ===== src/srcomp_mul.sv =====
`default_nettype none
// 64 x 64 multiply modulo 2^64, one 16-bit digit of the multiplier per cycle
module srcomp_mul (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  input  wire logic                              start_i,
  input  wire logic [srcomp_pkg::DATA_W-1:0]     a_i,
  input  wire logic [srcomp_pkg::DATA_W-1:0]     b_i,
  output logic                                   done_o,
  output logic [srcomp_pkg::DATA_W-1:0]          p_o
);
  import srcomp_pkg::*;

  logic                    busy_q;
  logic                    done_q;
  logic [MUL_CNT_W-1:0]    cnt_q;
  logic [DATA_W-1:0]       mc_q;
  logic [DATA_W-1:0]       mp_q;
  logic [DATA_W-1:0]       acc_q;
  logic [DATA_W-1:0]       part;

  // One partial product per cycle
  assign part = DATA_W'(mc_q * mp_q[MUL_DIGIT_W-1:0]);

  // Control: count digits, pulse done after the last one
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 1'b1;
        if (&cnt_q) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  // Datapath: accumulate and advance the digit window
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      mc_q  <= a_i;
      mp_q  <= b_i;
      acc_q <= '0;
    end else if (busy_q) begin
      acc_q <= acc_q + part;
      mc_q  <= mc_q << MUL_DIGIT_W;
      mp_q  <= mp_q >> MUL_DIGIT_W;
    end
  end

  assign done_o = done_q;
  assign p_o    = acc_q;

endmodule
`default_nettype wire

// ===== src/srcomp_div.sv =====
`default_nettype none
// Signed 64-bit division truncating toward zero, one quotient bit per cycle
module srcomp_div (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  input  wire logic                              start_i,
  input  wire logic [srcomp_pkg::DATA_W-1:0]     num_i,
  input  wire logic [srcomp_pkg::DATA_W-1:0]     den_i,
  output logic                                   done_o,
  output logic [srcomp_pkg::DATA_W-1:0]          quo_o
);
  import srcomp_pkg::*;

  logic                  busy_q;
  logic                  done_q;
  logic [DIV_CNT_W-1:0]  cnt_q;
  logic                  neg_q;
  logic [DATA_W-1:0]     rem_q;
  logic [DATA_W-1:0]     quo_q;
  logic [DATA_W-1:0]     den_q;
  logic [DATA_W:0]       rem_sh;
  logic [DATA_W:0]       diff;
  logic [DATA_W-1:0]     num_abs;
  logic [DATA_W-1:0]     den_abs;

  assign num_abs = num_i[DATA_W-1] ? (~num_i + 1'b1) : num_i;
  assign den_abs = den_i[DATA_W-1] ? (~den_i + 1'b1) : den_i;
  assign rem_sh  = {rem_q, quo_q[DATA_W-1]};
  assign diff    = rem_sh - {1'b0, den_q};

  // Control: one step per quotient bit
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 1'b1;
        if (&cnt_q) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  // Restoring division on magnitudes
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      neg_q <= num_i[DATA_W-1] ^ den_i[DATA_W-1];
      rem_q <= '0;
      quo_q <= num_abs;
      den_q <= den_abs;
    end else if (busy_q) begin
      if (!diff[DATA_W]) begin
        rem_q <= diff[DATA_W-1:0];
        quo_q <= {quo_q[DATA_W-2:0], 1'b1};
      end else begin
        rem_q <= rem_sh[DATA_W-1:0];
        quo_q <= {quo_q[DATA_W-2:0], 1'b0};
      end
    end
  end

  assign done_o = done_q;
  assign quo_o  = neg_q ? (~quo_q + 1'b1) : quo_q;

endmodule
`default_nettype wire

// ===== src/sensor_raw_compensation.sv =====
`default_nettype none
// Integer compensation of raw temperature, pressure and humidity readings.
// Input channel: in_valid_i/in_ready_o carry kind_i (0 temperature,
// 1 pressure, 2 humidity, 3 unused) and the 20-bit raw_reading_i.
// Output channel: out_valid_o/out_ready_i carry result_kind_o, the signed
// 33-bit value_o (0.01 degC, Pa*256 or %RH*1024) and divide_fault_o.
// Calibration words are written through cfg_we_i/cfg_index_i/cfg_data_i;
// the user must write them only while the block is idle, since the block
// does not enforce it. Writes to unknown indexes are dropped.
// One item is worked at a time. A sequencer drives a shared multiplier
// that retires one 16-bit digit per cycle and, for pressure only, a
// bit-serial divider; a pressure item with a zero divisor skips the divider.
// The next item can be accepted in the cycle after the result is handed
// to the output register.
// A temperature transaction updates the stored fine temperature used by
// later pressure and humidity transactions.
// The result sits in an output register; a new item is taken while it
// waits, and the next result holds in the core until the register frees.
// Reset clears the calibration registers and the fine temperature to zero.
module sensor_raw_compensation (
  input  wire logic                                 clk_i,
  input  wire logic                                 rst_ni,
  input  wire logic                                 in_valid_i,
  output logic                                      in_ready_o,
  input  wire logic [srcomp_pkg::KIND_W-1:0]        kind_i,
  input  wire logic [srcomp_pkg::RAW_W-1:0]         raw_reading_i,
  output logic                                      out_valid_o,
  input  wire logic                                 out_ready_i,
  output logic [srcomp_pkg::KIND_W-1:0]             result_kind_o,
  output logic signed [srcomp_pkg::VALUE_W-1:0]     value_o,
  output logic                                      divide_fault_o,
  input  wire logic                                 cfg_we_i,
  input  wire logic [srcomp_pkg::CFG_IDX_W-1:0]     cfg_index_i,
  input  wire logic [srcomp_pkg::CFG_W-1:0]         cfg_data_i
);
  import srcomp_pkg::*;

  typedef enum logic [5:0] {
    S_IDLE,
    S_T0, S_T1, S_T2, S_T3, S_T4,
    S_P0, S_P1, S_P2, S_P3, S_P4, S_P5, S_P6, S_P7, S_P8, S_P9, S_P10, S_P11,
    S_H0, S_H1, S_H2, S_H3, S_H4, S_H5, S_H6, S_H7, S_H8,
    S_MWAIT, S_DWAIT, S_FIN
  } state_e;

  localparam logic signed [DATA_W-1:0] T_BIAS    = 64'sd128;
  localparam logic signed [DATA_W-1:0] P_OFFSET  = 64'sd128000;
  localparam logic signed [DATA_W-1:0] P_ONE     = 64'sd1 <<< 47;
  localparam logic signed [DATA_W-1:0] P_FULL    = 64'sd1048576;
  localparam logic signed [DATA_W-1:0] P_SCALE   = 64'sd3125;
  localparam logic signed [DATA_W-1:0] H_OFFSET  = 64'sd76800;
  localparam logic signed [DATA_W-1:0] H_ROUND   = 64'sd16384;
  localparam logic signed [DATA_W-1:0] H_HALF    = 64'sd32768;
  localparam logic signed [DATA_W-1:0] H_BASE    = 64'sd2097152;
  localparam logic signed [DATA_W-1:0] H_ROUND2  = 64'sd8192;
  localparam logic signed [DATA_W-1:0] H_CLAMP   = 64'sd419430400;
  localparam logic signed [DATA_W-1:0] T_FIVE    = 64'sd5;

  // Calibration registers
  logic [47:0] temp_q;
  logic [63:0] plo_q;
  logic [63:0] phi_q;
  logic [15:0] p9_q;
  logic [31:0] hlo_q;
  logic [31:0] hhi_q;
  logic [31:0] fine_q;

  state_e                   state_q;
  state_e                   ret_q;
  logic [KIND_W-1:0]        kind_q;
  logic [RAW_W-1:0]         raw_q;
  logic signed [DATA_W-1:0] r0_q, r1_q, r2_q, r3_q;
  logic [VALUE_W-1:0]       val_q;
  logic                     fault_q;
  logic                     mul_start_q;
  logic [DATA_W-1:0]        mul_a_q, mul_b_q;
  logic                     div_start_q;
  logic [DATA_W-1:0]        div_n_q, div_d_q;
  logic                     out_valid_q;
  logic [KIND_W-1:0]        out_kind_q;
  logic [VALUE_W-1:0]       out_val_q;
  logic                     out_fault_q;

  logic                     mul_done, div_done;
  logic [DATA_W-1:0]        mul_pu, div_qu;
  logic signed [DATA_W-1:0] mp, dq;

  // Field extraction, sign- or zero-extended to the datapath width
  logic signed [DATA_W-1:0] t1, t2, t3;
  logic signed [DATA_W-1:0] p1, p2, p3, p4, p5, p6, p7, p8, p9;
  logic signed [DATA_W-1:0] h1, h2, h3, h4, h5, h6;
  logic signed [DATA_W-1:0] tf, raw64, hr64;
  logic signed [DATA_W-1:0] t_a, t_d, f_sum, p_a, p_c, h_x, h_s1, h_fin, h_clamped;

  assign t1 = $signed({48'd0, temp_q[15:0]});
  assign t2 = $signed({{48{temp_q[31]}}, temp_q[31:16]});
  assign t3 = $signed({{48{temp_q[47]}}, temp_q[47:32]});
  assign p1 = $signed({48'd0, plo_q[15:0]});
  assign p2 = $signed({{48{plo_q[31]}}, plo_q[31:16]});
  assign p3 = $signed({{48{plo_q[47]}}, plo_q[47:32]});
  assign p4 = $signed({{48{plo_q[63]}}, plo_q[63:48]});
  assign p5 = $signed({{48{phi_q[15]}}, phi_q[15:0]});
  assign p6 = $signed({{48{phi_q[31]}}, phi_q[31:16]});
  assign p7 = $signed({{48{phi_q[47]}}, phi_q[47:32]});
  assign p8 = $signed({{48{phi_q[63]}}, phi_q[63:48]});
  assign p9 = $signed({{48{p9_q[15]}}, p9_q});
  assign h1 = $signed({56'd0, hlo_q[7:0]});
  assign h2 = $signed({{48{hlo_q[23]}}, hlo_q[23:8]});
  assign h3 = $signed({56'd0, hlo_q[31:24]});
  assign h4 = $signed({{52{hhi_q[11]}}, hhi_q[11:0]});
  assign h5 = $signed({{52{hhi_q[23]}}, hhi_q[23:12]});
  assign h6 = $signed({{56{hhi_q[31]}}, hhi_q[31:24]});
  assign tf    = $signed({{32{fine_q[31]}}, fine_q});
  assign raw64 = $signed({44'd0, raw_q});
  assign hr64  = $signed({48'd0, raw_q[15:0]});
  assign mp    = $signed(mul_pu);
  assign dq    = $signed(div_qu);

  // Step expressions of the sequencer
  assign t_a   = $signed({47'd0, raw_q[19:3]}) - (t1 <<< 1);
  assign t_d   = $signed({48'd0, raw_q[19:4]}) - t1;
  assign f_sum = r0_q + (mp >>> 14);
  assign p_a   = tf - P_OFFSET;
  assign p_c   = mp >>> 33;
  assign h_x   = tf - H_OFFSET;
  assign h_s1  = ((hr64 <<< 14) - (h4 <<< 20) - mp + H_ROUND) >>> 15;
  assign h_fin = r0_q - (mp >>> 4);

  // Clamp humidity before the final shift
  always_comb begin
    priority if (h_fin < 0) begin
      h_clamped = '0;
    end else if (h_fin > H_CLAMP) begin
      h_clamped = H_CLAMP;
    end else begin
      h_clamped = h_fin;
    end
  end

  // Calibration writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      temp_q <= '0;
      plo_q  <= '0;
      phi_q  <= '0;
      p9_q   <= '0;
      hlo_q  <= '0;
      hhi_q  <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        CFG_TEMP:   temp_q <= cfg_data_i[47:0];
        CFG_P_LOW:  plo_q  <= cfg_data_i;
        CFG_P_HIGH: phi_q  <= cfg_data_i;
        CFG_P_NINE: p9_q   <= cfg_data_i[15:0];
        CFG_H_LOW:  hlo_q  <= cfg_data_i[31:0];
        CFG_H_HIGH: hhi_q  <= cfg_data_i[31:0];
        default: ;
      endcase
    end
  end

  // Sequencer with registered outputs
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      ret_q       <= S_IDLE;
      fine_q      <= '0;
      mul_start_q <= 1'b0;
      div_start_q <= 1'b0;
      out_valid_q <= 1'b0;
      kind_q      <= '0;
      raw_q       <= '0;
      r0_q        <= '0;
      r1_q        <= '0;
      r2_q        <= '0;
      r3_q        <= '0;
      val_q       <= '0;
      fault_q     <= 1'b0;
      mul_a_q     <= '0;
      mul_b_q     <= '0;
      div_n_q     <= '0;
      div_d_q     <= '0;
      out_kind_q  <= '0;
      out_val_q   <= '0;
      out_fault_q <= 1'b0;
    end else begin
      mul_start_q <= 1'b0;
      div_start_q <= 1'b0;
      if (out_valid_q && out_ready_i && (state_q != S_FIN)) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        S_IDLE: begin
          if (in_valid_i) begin
            kind_q  <= kind_i;
            raw_q   <= raw_reading_i;
            val_q   <= '0;
            fault_q <= 1'b0;
            unique case (kind_i)
              KIND_TEMP:  state_q <= S_T0;
              KIND_PRESS: state_q <= S_P0;
              KIND_HUM:   state_q <= S_H0;
              default:    state_q <= S_FIN;
            endcase
          end
        end
        // Temperature
        S_T0: begin
          r1_q <= t_d;
          mul_a_q <= t_a; mul_b_q <= t2; mul_start_q <= 1'b1;
          ret_q <= S_T1; state_q <= S_MWAIT;
        end
        S_T1: begin
          r0_q <= mp >>> 11;
          mul_a_q <= r1_q; mul_b_q <= r1_q; mul_start_q <= 1'b1;
          ret_q <= S_T2; state_q <= S_MWAIT;
        end
        S_T2: begin
          mul_a_q <= mp >>> 12; mul_b_q <= t3; mul_start_q <= 1'b1;
          ret_q <= S_T3; state_q <= S_MWAIT;
        end
        S_T3: begin
          fine_q <= f_sum[31:0];
          mul_a_q <= {{32{f_sum[31]}}, f_sum[31:0]}; mul_b_q <= T_FIVE;
          mul_start_q <= 1'b1;
          ret_q <= S_T4; state_q <= S_MWAIT;
        end
        S_T4: begin
          val_q <= VALUE_W'((mp + T_BIAS) >>> 8);
          state_q <= S_FIN;
        end
        // Pressure
        S_P0: begin
          r0_q <= p_a;
          mul_a_q <= p_a; mul_b_q <= p_a; mul_start_q <= 1'b1;
          ret_q <= S_P1; state_q <= S_MWAIT;
        end
        S_P1: begin
          r1_q <= mp;
          mul_a_q <= mp; mul_b_q <= p6; mul_start_q <= 1'b1;
          ret_q <= S_P2; state_q <= S_MWAIT;
        end
        S_P2: begin
          r2_q <= mp;
          mul_a_q <= r0_q; mul_b_q <= p5; mul_start_q <= 1'b1;
          ret_q <= S_P3; state_q <= S_MWAIT;
        end
        S_P3: begin
          r2_q <= r2_q + (mp <<< 17) + (p4 <<< 35);
          mul_a_q <= r1_q; mul_b_q <= p3; mul_start_q <= 1'b1;
          ret_q <= S_P4; state_q <= S_MWAIT;
        end
        S_P4: begin
          r3_q <= mp >>> 8;
          mul_a_q <= r0_q; mul_b_q <= p2; mul_start_q <= 1'b1;
          ret_q <= S_P5; state_q <= S_MWAIT;
        end
        S_P5: begin
          mul_a_q <= P_ONE + r3_q + (mp <<< 12); mul_b_q <= p1; mul_start_q <= 1'b1;
          ret_q <= S_P6; state_q <= S_MWAIT;
        end
        S_P6: begin
          if (p_c == 0) begin
            fault_q <= 1'b1;
            state_q <= S_FIN;
          end else begin
            r3_q <= p_c;
            mul_a_q <= ((P_FULL - raw64) <<< 31) - r2_q; mul_b_q <= P_SCALE;
            mul_start_q <= 1'b1;
            ret_q <= S_P7; state_q <= S_MWAIT;
          end
        end
        S_P7: begin
          div_n_q <= mp; div_d_q <= r3_q; div_start_q <= 1'b1;
          ret_q <= S_P8; state_q <= S_DWAIT;
        end
        S_P8: begin
          r0_q <= dq;
          r1_q <= dq >>> 13;
          mul_a_q <= p9; mul_b_q <= dq >>> 13; mul_start_q <= 1'b1;
          ret_q <= S_P9; state_q <= S_MWAIT;
        end
        S_P9: begin
          mul_a_q <= mp; mul_b_q <= r1_q; mul_start_q <= 1'b1;
          ret_q <= S_P10; state_q <= S_MWAIT;
        end
        S_P10: begin
          r2_q <= mp >>> 25;
          mul_a_q <= p8; mul_b_q <= r0_q; mul_start_q <= 1'b1;
          ret_q <= S_P11; state_q <= S_MWAIT;
        end
        S_P11: begin
          val_q <= VALUE_W'(((r0_q + r2_q + (mp >>> 19)) >>> 8) + (p7 <<< 4));
          state_q <= S_FIN;
        end
        // Humidity
        S_H0: begin
          r0_q <= h_x;
          mul_a_q <= h5; mul_b_q <= h_x; mul_start_q <= 1'b1;
          ret_q <= S_H1; state_q <= S_MWAIT;
        end
        S_H1: begin
          r1_q <= h_s1;
          mul_a_q <= r0_q; mul_b_q <= h6; mul_start_q <= 1'b1;
          ret_q <= S_H2; state_q <= S_MWAIT;
        end
        S_H2: begin
          r2_q <= mp >>> 10;
          mul_a_q <= r0_q; mul_b_q <= h3; mul_start_q <= 1'b1;
          ret_q <= S_H3; state_q <= S_MWAIT;
        end
        S_H3: begin
          mul_a_q <= r2_q; mul_b_q <= (mp >>> 11) + H_HALF; mul_start_q <= 1'b1;
          ret_q <= S_H4; state_q <= S_MWAIT;
        end
        S_H4: begin
          mul_a_q <= (mp >>> 10) + H_BASE; mul_b_q <= h2; mul_start_q <= 1'b1;
          ret_q <= S_H5; state_q <= S_MWAIT;
        end
        S_H5: begin
          mul_a_q <= r1_q; mul_b_q <= (mp + H_ROUND2) >>> 14; mul_start_q <= 1'b1;
          ret_q <= S_H6; state_q <= S_MWAIT;
        end
        S_H6: begin
          r0_q <= mp;
          mul_a_q <= mp >>> 15; mul_b_q <= mp >>> 15; mul_start_q <= 1'b1;
          ret_q <= S_H7; state_q <= S_MWAIT;
        end
        S_H7: begin
          mul_a_q <= mp >>> 7; mul_b_q <= h1; mul_start_q <= 1'b1;
          ret_q <= S_H8; state_q <= S_MWAIT;
        end
        S_H8: begin
          val_q <= VALUE_W'(h_clamped >>> 12);
          state_q <= S_FIN;
        end
        // Wait on the shared units
        S_MWAIT: begin
          if (mul_done) begin
            state_q <= ret_q;
          end
        end
        S_DWAIT: begin
          if (div_done) begin
            state_q <= ret_q;
          end
        end
        // Hand the result to the output register once it is free
        S_FIN: begin
          if (!out_valid_q || out_ready_i) begin
            out_valid_q <= 1'b1;
            out_kind_q  <= kind_q;
            out_val_q   <= val_q;
            out_fault_q <= fault_q;
            state_q     <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  srcomp_mul u_mul (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (mul_start_q),
    .a_i     (mul_a_q),
    .b_i     (mul_b_q),
    .done_o  (mul_done),
    .p_o     (mul_pu)
  );

  srcomp_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start_q),
    .num_i   (div_n_q),
    .den_i   (div_d_q),
    .done_o  (div_done),
    .quo_o   (div_qu)
  );

  assign in_ready_o     = (state_q == S_IDLE);
  assign out_valid_o    = out_valid_q;
  assign result_kind_o  = out_kind_q;
  assign value_o        = $signed(out_val_q);
  assign divide_fault_o = out_fault_q;

endmodule
`default_nettype wire

// ===== src/srcomp_chk.sv =====
`default_nettype none
module srcomp_chk (
  input wire logic                                 clk_i,
  input wire logic                                 rst_ni,
  input wire logic                                 in_valid_i,
  input wire logic                                 in_ready_o,
  input wire logic                                 out_valid_o,
  input wire logic [srcomp_pkg::KIND_W-1:0]        result_kind_o,
  input wire logic signed [srcomp_pkg::VALUE_W-1:0] value_o,
  input wire logic                                 divide_fault_o
);
  import srcomp_pkg::*;

  // Fault only on pressure results
  a_fault_kind: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && divide_fault_o |-> result_kind_o == KIND_PRESS)
    else $error("divide fault on non-pressure result");

  // Faulted result carries zero
  a_fault_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && divide_fault_o |-> value_o == '0)
    else $error("divide fault with nonzero value");

  // Unused kind yields zero
  a_none_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && result_kind_o == KIND_NONE |-> value_o == '0)
    else $error("unused kind with nonzero value");

  // Humidity stays within its clamped range
  a_hum_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && result_kind_o == KIND_HUM |->
      !value_o[VALUE_W-1] && ($unsigned(value_o) <= HUM_MAX_OUT))
    else $error("humidity out of range");

  // Busy after taking a transaction
  a_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("ready right after accept");

endmodule

bind sensor_raw_compensation srcomp_chk u_chk (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .in_valid_i     (in_valid_i),
  .in_ready_o     (in_ready_o),
  .out_valid_o    (out_valid_o),
  .result_kind_o  (result_kind_o),
  .value_o        (value_o),
  .divide_fault_o (divide_fault_o)
);
`default_nettype wire

// ===== bench/testbench.sv =====
`timescale 1ns / 1ps
module testbench;
  import srcomp_pkg::*;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid_i = 1'b0;
  logic in_ready_o;
  logic [KIND_W-1:0] kind_i = '0;
  logic [RAW_W-1:0] raw_reading_i = '0;
  logic out_valid_o;
  logic out_ready_i = 1'b0;
  logic [KIND_W-1:0] result_kind_o;
  logic signed [VALUE_W-1:0] value_o;
  logic divide_fault_o;
  logic cfg_we_i = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index_i = '0;
  logic [CFG_W-1:0] cfg_data_i = '0;

  sensor_raw_compensation DUT (.*);

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  typedef struct packed {
    logic [KIND_W-1:0] kind;
    logic [VALUE_W-1:0] value;
    logic fault;
  } reading_t;

  // Calibration shadow and fine temperature
  logic [63:0] cal_temp, cal_plo, cal_phi, cal_p9, cal_hlo, cal_hhi;
  logic signed [31:0] fine_t;
  reading_t expected_q[$];
  int errors = 0;
  int idle_pct = 7;
  int idle_cycles = 0;
  bit done = 0;

  function automatic logic signed [63:0] sxt(logic [63:0] r, int lo, int w);
    logic [63:0] v;
    v = (r >> lo) & ((64'd1 << w) - 1);
    if (v[w-1]) v = v | ~((64'd1 << w) - 1);
    return v;
  endfunction

  function automatic logic [63:0] uxt(logic [63:0] r, int lo, int w);
    return (r >> lo) & ((64'd1 << w) - 1);
  endfunction

  // Compensate one reading; updates fine temperature on a temperature reading
  function automatic reading_t compensate(logic [1:0] kind, logic [19:0] raw);
    reading_t r;
    logic signed [63:0] a, b, p, d, x, s1, s2, t1, t2, t3, tf, v;
    r.kind = kind;
    r.fault = 1'b0;
    v = 0;
    tf = fine_t;
    case (kind)
      KIND_TEMP: begin
        t1 = uxt(cal_temp, 0, 16);
        t2 = sxt(cal_temp, 16, 16);
        t3 = sxt(cal_temp, 32, 16);
        a = (raw >> 3) - (t1 << 1);
        d = (raw >> 4) - t1;
        a = ((a * t2) >>> 11) + ((((d * d) >>> 12) * t3) >>> 14);
        fine_t = a[31:0];
        a = fine_t;
        v = (a * 5 + 128) >>> 8;
      end
      KIND_PRESS: begin
        a = tf - 128000;
        b = a * a * sxt(cal_phi, 16, 16);
        b = b + ((a * sxt(cal_phi, 0, 16)) << 17);
        b = b + (sxt(cal_plo, 48, 16) << 35);
        a = ((a * a * sxt(cal_plo, 32, 16)) >>> 8) + ((a * sxt(cal_plo, 16, 16)) << 12);
        a = (((64'sd1 <<< 47) + a) * $signed(uxt(cal_plo, 0, 16))) >>> 33;
        if (a == 0) r.fault = 1'b1;
        else begin
          p = 1048576 - raw;
          p = ((p << 31) - b) * 3125;
          if (p == {1'b1, 63'd0} && a == -1) p = p;
          else p = p / a;
          x = (sxt(cal_p9, 0, 16) * (p >>> 13) * (p >>> 13)) >>> 25;
          s1 = (sxt(cal_phi, 48, 16) * p) >>> 19;
          v = ((p + x + s1) >>> 8) + (sxt(cal_phi, 32, 16) << 4);
        end
      end
      KIND_HUM: begin
        x = tf - 76800;
        s1 = (($signed({48'd0, raw[15:0]}) <<< 14) - (sxt(cal_hhi, 0, 12) << 20)
              - sxt(cal_hhi, 12, 12) * x + 16384) >>> 15;
        s2 = ((x * sxt(cal_hhi, 24, 8)) >>> 10)
             * (((x * $signed(uxt(cal_hlo, 24, 8))) >>> 11) + 32768);
        s2 = (s2 >>> 10) + 2097152;
        s2 = (s2 * sxt(cal_hlo, 8, 16) + 8192) >>> 14;
        x = s1 * s2;
        x = x - (((((x >>> 15) * (x >>> 15)) >>> 7) * $signed(uxt(cal_hlo, 0, 8))) >>> 4);
        if (x < 0) x = 0;
        if (x > 419430400) x = 419430400;
        v = x >>> 12;
      end
      default: v = 0;
    endcase
    r.value = v[VALUE_W-1:0];
    return r;
  endfunction

  // Check each result against the oldest expectation
  always @(posedge clk_i) begin
    if (out_valid_o && out_ready_i) begin
      if (expected_q.size() == 0) begin
        $error("unexpected result kind %0d", result_kind_o);
        errors++;
      end else begin
        reading_t e;
        e = expected_q.pop_front();
        if (result_kind_o !== e.kind) begin
          $error("result_kind exp %0d got %0d", e.kind, result_kind_o); errors++;
        end
        if (value_o !== e.value) begin
          $error("value exp %0h got %0h", e.value, value_o); errors++;
        end
        if (divide_fault_o !== e.fault) begin
          $error("divide_fault exp %0d got %0d", e.fault, divide_fault_o); errors++;
        end
      end
    end
  end

  // Randomly stall the result side
  always @(posedge clk_i) out_ready_i <= ($urandom_range(99) >= idle_pct);

  // Watchdog on cycles with no transaction
  always @(posedge clk_i) begin
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (!done && idle_cycles > 20000) begin
      $display("FAIL");
      $finish;
    end
  end

  // Hold valid across items sent back to back; drop it only while idling
  task automatic send_reading(logic [1:0] kind, logic [19:0] raw);
    while ($urandom_range(99) < idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    kind_i <= kind;
    raw_reading_i <= raw;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    expected_q.push_back(compensate(kind, raw));
  endtask

  task automatic drain;
    in_valid_i <= 1'b0;
    while (expected_q.size() != 0) @(posedge clk_i);
    repeat (200) @(posedge clk_i);
  endtask

  // Write enable stays high across consecutive writes; the caller drops it
  task automatic write_cal(cfg_idx_e idx, logic [63:0] data);
    cfg_we_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= data;
    @(posedge clk_i);
    case (idx)
      CFG_TEMP: cal_temp = data & 64'hFFFF_FFFF_FFFF;
      CFG_P_LOW: cal_plo = data;
      CFG_P_HIGH: cal_phi = data;
      CFG_P_NINE: cal_p9 = data & 64'hFFFF;
      CFG_H_LOW: cal_hlo = data & 64'hFFFF_FFFF;
      default: cal_hhi = data & 64'hFFFF_FFFF;
    endcase
  endtask

  // Typical factory calibration
  task automatic load_typical;
    write_cal(CFG_TEMP, {16'd0, 16'd50, 16'd26435, 16'd27504});
    write_cal(CFG_P_LOW, {16'd2855, 16'd3024, -16'sd10685, 16'd36477});
    write_cal(CFG_P_HIGH, {-16'sd7, 16'd15500, -16'sd7, 16'd140});
    write_cal(CFG_P_NINE, 64'd4000);
    write_cal(CFG_H_LOW, {32'd0, 8'd0, 16'd361, 8'd75});
    write_cal(CFG_H_HIGH, {32'd0, 8'd30, 12'd50, 12'd313});
    cfg_we_i <= 1'b0;
  endtask

  task automatic load_random;
    write_cal(CFG_TEMP, {$urandom, $urandom});
    write_cal(CFG_P_LOW, {$urandom, $urandom});
    write_cal(CFG_P_HIGH, {$urandom, $urandom});
    write_cal(CFG_P_NINE, {$urandom, $urandom});
    write_cal(CFG_H_LOW, {$urandom, $urandom});
    write_cal(CFG_H_HIGH, {$urandom, $urandom});
    cfg_we_i <= 1'b0;
  endtask

  task automatic test_reset_state;
    // all-zero calibration: pressure divisor zero
    send_reading(KIND_PRESS, 20'h80000);
    send_reading(KIND_HUM, 20'hFFFFF);
    send_reading(KIND_TEMP, 20'h00000);
    send_reading(KIND_NONE, 20'hFFFFF);
    drain();
  endtask

  task automatic test_directed;
    load_typical();
    send_reading(KIND_TEMP, 20'd519888);
    send_reading(KIND_PRESS, 20'd415148);
    send_reading(KIND_HUM, 20'd28000);
    send_reading(KIND_PRESS, 20'h00000);
    send_reading(KIND_PRESS, 20'hFFFFF);
    send_reading(KIND_HUM, 20'h00000);
    send_reading(KIND_HUM, 20'hFFFFF);
    send_reading(KIND_TEMP, 20'hFFFFF);
    send_reading(KIND_HUM, 20'h0FFFF);
    send_reading(KIND_TEMP, 20'h00000);
    send_reading(KIND_PRESS, 20'h12345);
    send_reading(KIND_NONE, 20'h5A5A5);
    drain();
    // extreme calibration words
    write_cal(CFG_TEMP, 64'hFFFF_FFFF_FFFF);
    write_cal(CFG_P_LOW, 64'hFFFF_FFFF_FFFF_FFFF);
    write_cal(CFG_P_HIGH, 64'h8000_8000_8000_8000);
    write_cal(CFG_P_NINE, 64'h8000);
    write_cal(CFG_H_LOW, 64'hFF80_00FF);
    write_cal(CFG_H_HIGH, 64'h8080_0800);
    cfg_we_i <= 1'b0;
    send_reading(KIND_TEMP, 20'hFFFFF);
    send_reading(KIND_PRESS, 20'h00000);
    send_reading(KIND_HUM, 20'hFFFFF);
    send_reading(KIND_TEMP, 20'h00000);
    send_reading(KIND_PRESS, 20'hFFFFF);
    send_reading(KIND_HUM, 20'h00000);
    drain();
  endtask

  // Random kinds: one in twenty is the unused kind, the rest temperature, pressure or humidity
  task automatic run_random(int count);
    logic [1:0] k;
    for (int i = 0; i < count; i++) begin
      k = ($urandom_range(19) == 0) ? KIND_NONE : 2'($urandom_range(2));
      send_reading(k, 20'($urandom));
    end
  endtask

  task automatic test_random;
    load_typical();
    run_random(300);
    drain();
    idle_pct = 0;
    run_random(200);
    drain();
    idle_pct = 7;
    for (int s = 0; s < 7; s++) begin
      if (s % 2 == 0) load_random();
      else load_typical();
      run_random(100);
      drain();
    end
  endtask

  initial begin
    cal_temp = 0; cal_plo = 0; cal_phi = 0; cal_p9 = 0; cal_hlo = 0; cal_hhi = 0;
    fine_t = 0;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_reset_state();
    test_directed();
    test_random();
    done = 1;
    if (errors == 0) $display("PASS");
    else $display("FAIL");
    $finish;
  end

endmodule
